// File: rtl/atl_pkg.sv
// Package for the assembly text lexer: token and error codes, character
// constants, result type and the decode of a character seen between runs.
// No dependencies.
`timescale 1ns / 1ps

package atl_pkg;

  // Scanner and symbol search states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_REG     = 12'b0000_0000_0010,
    ST_NUM     = 12'b0000_0000_0100,
    ST_TILDE   = 12'b0000_0000_1000,
    ST_COMMENT = 12'b0000_0001_0000,
    ST_NAME    = 12'b0000_0010_0000,
    ST_HALT    = 12'b0000_0100_0000,
    ST_LEN_RD  = 12'b0000_1000_0000,
    ST_LEN_CHK = 12'b0001_0000_0000,
    ST_CH_RD   = 12'b0010_0000_0000,
    ST_CH_CHK  = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_e;

  // Token kinds
  localparam logic [3:0] TK_END      = 4'd0;
  localparam logic [3:0] TK_REG      = 4'd1;
  localparam logic [3:0] TK_LIT      = 4'd2;
  localparam logic [3:0] TK_COMMA    = 4'd3;
  localparam logic [3:0] TK_LBRACK   = 4'd4;
  localparam logic [3:0] TK_RBRACK   = 4'd5;
  localparam logic [3:0] TK_LPAREN   = 4'd6;
  localparam logic [3:0] TK_RPAREN   = 4'd7;
  localparam logic [3:0] TK_PLUS     = 4'd8;
  localparam logic [3:0] TK_MINUS    = 4'd9;
  localparam logic [3:0] TK_STAR     = 4'd10;
  localparam logic [3:0] TK_SLASH    = 4'd11;
  localparam logic [3:0] TK_LABEL    = 4'd12;
  localparam logic [3:0] TK_MNEMONIC = 4'd13;
  localparam logic [3:0] TK_ERROR    = 4'd14;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_BAD_REG   = 3'd2;
  localparam logic [2:0] ERR_BAD_CMT   = 3'd3;
  localparam logic [2:0] ERR_NAME_LONG = 3'd4;
  localparam logic [2:0] ERR_NO_COLON  = 3'd5;
  localparam logic [2:0] ERR_TAB_FULL  = 3'd6;
  localparam logic [2:0] ERR_NUM_LONG  = 3'd7;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [2:0]  err;
  } res_t;

  // What a character does when no run is open
  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic [2:0] err;
    state_e     nxt;
    logic       start_reg;
    logic       start_num;
    logic       start_name;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Hex digit value; bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61) && (c <= 8'h66)) r = {1'b1, 4'(c[3:0] + 4'd9)};
    else if ((c >= 8'h41) && (c <= 8'h46)) r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  // Mnemonic id 1..12, 0 when the three characters name none
  function automatic logic [3:0] mnem_id(input logic [23:0] s);
    logic [3:0] r;
    case (s)
      "lvr":   r = 4'd1;
      "add":   r = 4'd2;
      "sub":   r = 4'd3;
      "mul":   r = 4'd4;
      "div":   r = 4'd5;
      "lfp":   r = 4'd6;
      "lpi":   r = 4'd7;
      "lpo":   r = 4'd8;
      "slv":   r = 4'd9;
      "vts":   r = 4'd10;
      "vfs":   r = 4'd11;
      "com":   r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic idle_t idle_decode(input logic [7:0] c);
    idle_t r;
    r = '{emit: 1'b1, kind: TK_END, err: ERR_NONE, nxt: ST_IDLE,
          start_reg: 1'b0, start_num: 1'b0, start_name: 1'b0};
    case (c)
      CH_NUL:   r.kind = TK_END;
      CH_SPACE, CH_TAB, CH_LF: r.emit = 1'b0;
      CH_PCT: begin
        r.emit = 1'b0; r.nxt = ST_REG; r.start_reg = 1'b1;
      end
      CH_DOLLAR: begin
        r.emit = 1'b0; r.nxt = ST_NUM; r.start_num = 1'b1;
      end
      CH_COMMA: r.kind = TK_COMMA;
      CH_LBRK:  r.kind = TK_LBRACK;
      CH_RBRK:  r.kind = TK_RBRACK;
      CH_LPAR:  r.kind = TK_LPAREN;
      CH_RPAR:  r.kind = TK_RPAREN;
      CH_PLUS:  r.kind = TK_PLUS;
      CH_MINUS: r.kind = TK_MINUS;
      CH_STAR:  r.kind = TK_STAR;
      CH_SLASH: r.kind = TK_SLASH;
      CH_TILDE: begin
        r.emit = 1'b0; r.nxt = ST_TILDE;
      end
      default: begin
        if (is_alpha(c) || (c == CH_UNDER)) begin
          r.emit = 1'b0; r.nxt = ST_NAME; r.start_name = 1'b1;
        end else begin
          r.kind = TK_ERROR; r.err = ERR_BAD_CHAR; r.nxt = ST_HALT;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/assembly_text_lexer.sv
// Assembly text lexer: one character in per transfer, tokens out as transfers.
// Tokens leave from an output register. Throughput: one character per cycle while
// the token side takes tokens; a second token from one character holds the input
// until it reaches the output register. A label end holds it while stored labels
// are compared by length and, where lengths match, by name character.
// Reset: asynchronous, active low; clears scanner state and empties the symbol table.
`timescale 1ns / 1ps

module assembly_text_lexer
  import atl_pkg::*;
#(
  parameter int MAX_SYMBOLS    = 512,
  parameter int NAME_BUF       = 128,
  parameter int NUMBER_BUF     = 64,
  parameter int REGISTER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] token_value, [34:32] error_code
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int RMAX = (NAME_BUF + 1 > NUMBER_BUF) ? NAME_BUF + 1 : NUMBER_BUF;
  localparam int RLW  = $clog2(RMAX + 1);
  localparam int JW   = $clog2(NAME_BUF);
  localparam int IW   = $clog2(MAX_SYMBOLS + 1);
  localparam int LIW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int AW   = (MAX_SYMBOLS * NAME_BUF > 1) ? $clog2(MAX_SYMBOLS * NAME_BUF) : 1;

  // Memories
  logic [7:0]    nb_mem  [NAME_BUF];
  logic [7:0]    sym_mem [MAX_SYMBOLS * NAME_BUF];
  logic [JW-1:0] len_mem [MAX_SYMBOLS];

  // Control registers
  state_e          state_q, state_d;
  logic [RLW-1:0]  run_len_q, run_len_d;
  logic [31:0]     dacc_q, dacc_d, hacc_q, hacc_d;
  logic            lf_zero_q, lf_zero_d, lf_hex_q, lf_hex_d;
  logic            lf_dstop_q, lf_dstop_d, lf_hstop_q, lf_hstop_d;
  logic [IW-1:0]   count_q, count_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [JW-1:0]   j_q, j_d;
  logic [AW-1:0]   base_q, base_d, wbase_q, wbase_d;
  logic            found_q, found_d;
  logic [7:0]      term_q, term_d;
  logic [7:0]      f0_q, f0_d, f1_q, f1_d, f2_q, f2_d, last_q, last_d;

  // Output register and its overflow stage
  res_t  out_q, pend_q;
  logic  out_last_q, out_valid_q, pend_valid_q;

  // Memory ports
  logic          nb_we, sym_we, len_we;
  logic [JW-1:0] nb_waddr, nb_raddr;
  logic [AW-1:0] sym_waddr, sym_raddr;
  logic [LIW-1:0] len_waddr, len_raddr;
  logic [7:0]    wr_char, nb_rd_q, sym_rd_q;
  logic [JW-1:0] len_wdata, len_rd_q;

  logic        space, fire_in, step;
  logic [7:0]  cur_c;
  idle_t       idl;
  logic        do_idle;
  logic        r1_v;
  res_t        r1;
  logic        halt_now;
  logic [4:0]  hv;
  logic        reg_ok;
  logic [6:0]  reg_num;
  logic [3:0]  mnem;
  logic [JW-1:0] name_len;
  logic [JW-1:0] j_inc;
  logic [IW-1:0] idx_inc;
  logic        n_res2;
  res_t        first_res, second_res;
  logic        any_res;

  assign space   = !pend_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = space && (state_q inside {ST_IDLE, ST_REG, ST_NUM, ST_TILDE,
                                                   ST_COMMENT, ST_NAME, ST_HALT});
  assign fire_in = s_axis_tvalid && s_axis_tready;
  assign step    = fire_in || ((state_q == ST_DONE) && space);
  assign cur_c   = (state_q == ST_DONE) ? term_q : s_axis_tdata;
  assign idl     = idle_decode(cur_c);
  assign hv      = hex_val(cur_c);
  assign mnem    = mnem_id({f0_q, f1_q, f2_q});
  assign name_len = JW'(run_len_q - RLW'(1));
  assign j_inc   = JW'(j_q + JW'(1));
  assign idx_inc = IW'(idx_q + IW'(1));

  // Register name check on the first three characters held
  always_comb begin
    reg_num = (run_len_q == RLW'(3)) ? 7'(7'(f1_q[3:0]) * 7'd10 + 7'(f2_q[3:0]))
                                     : 7'(f1_q[3:0]);
    reg_ok  = ((run_len_q == RLW'(2)) || (run_len_q == RLW'(3))) && (f0_q == CH_R) &&
              is_digit(f1_q) &&
              ((run_len_q == RLW'(2)) || ((f1_q != CH_ZERO) && is_digit(f2_q))) &&
              ({1'b0, reg_num} < 8'(REGISTER_COUNT));
  end

  // Scanner and symbol search
  always_comb begin
    state_d    = state_q;
    run_len_d  = run_len_q;
    dacc_d     = dacc_q;
    hacc_d     = hacc_q;
    lf_zero_d  = lf_zero_q;
    lf_hex_d   = lf_hex_q;
    lf_dstop_d = lf_dstop_q;
    lf_hstop_d = lf_hstop_q;
    count_d    = count_q;
    idx_d      = idx_q;
    j_d        = j_q;
    base_d     = base_q;
    wbase_d    = wbase_q;
    found_d    = found_q;
    term_d     = term_q;
    f0_d       = f0_q;
    f1_d       = f1_q;
    f2_d       = f2_q;
    last_d     = last_q;
    do_idle    = 1'b0;
    r1_v       = 1'b0;
    r1         = '{kind: TK_END, value: 32'd0, err: ERR_NONE};
    halt_now   = 1'b0;
    nb_we      = 1'b0;
    sym_we     = 1'b0;
    len_we     = 1'b0;
    nb_waddr   = run_len_q[JW-1:0];
    sym_waddr  = AW'(wbase_q + AW'(run_len_q));
    wr_char    = cur_c;
    len_waddr  = count_q[LIW-1:0];
    len_wdata  = name_len;
    nb_raddr   = j_q;
    sym_raddr  = AW'(base_q + AW'(j_q));
    len_raddr  = idx_q[LIW-1:0];

    unique case (state_q)
      ST_IDLE: if (step) do_idle = 1'b1;
      ST_REG: if (step) begin
        if (is_alpha(cur_c) || is_digit(cur_c)) begin
          if (run_len_q < RLW'(NAME_BUF)) begin
            if (run_len_q == RLW'(0)) f0_d = cur_c;
            if (run_len_q == RLW'(1)) f1_d = cur_c;
            if (run_len_q == RLW'(2)) f2_d = cur_c;
            run_len_d = RLW'(run_len_q + RLW'(1));
          end
        end else if (!reg_ok) begin
          r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_BAD_REG};
          halt_now = 1'b1;
        end else begin
          r1_v = 1'b1; r1 = '{kind: TK_REG, value: 32'(reg_num), err: ERR_NONE};
          do_idle = 1'b1;
        end
      end
      ST_NUM: if (step) begin
        if (hv[4] || (cur_c == CH_X)) begin
          if (run_len_q >= RLW'(NUMBER_BUF - 1)) begin
            r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_NUM_LONG};
            halt_now = 1'b1;
          end else begin
            if ((run_len_q == RLW'(0)) && (cur_c == CH_ZERO)) lf_zero_d = 1'b1;
            if ((run_len_q == RLW'(1)) && lf_zero_q && (cur_c == CH_X)) lf_hex_d = 1'b1;
            if ((run_len_q >= RLW'(2)) && lf_hex_q && !lf_hstop_q) begin
              if (hv[4]) hacc_d = {hacc_q[27:0], hv[3:0]};
              else lf_hstop_d = 1'b1;
            end
            if (!lf_dstop_q) begin
              if (is_digit(cur_c)) begin
                dacc_d = 32'({dacc_q[28:0], 3'b0} + {dacc_q[30:0], 1'b0} +
                             32'(cur_c[3:0]));
              end else begin
                lf_dstop_d = 1'b1;
              end
            end
            run_len_d = RLW'(run_len_q + RLW'(1));
          end
        end else begin
          r1_v = 1'b1;
          r1 = '{kind: TK_LIT, value: lf_hex_q ? hacc_q : dacc_q, err: ERR_NONE};
          do_idle = 1'b1;
        end
      end
      ST_TILDE: if (step) begin
        if (cur_c == CH_TILDE) state_d = ST_COMMENT;
        else begin
          r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_BAD_CMT};
          halt_now = 1'b1;
        end
      end
      ST_COMMENT: if (step) begin
        if (cur_c == CH_LF) state_d = ST_IDLE;
        else if (cur_c == CH_NUL) begin
          r1_v = 1'b1; r1 = '{kind: TK_END, value: 32'd0, err: ERR_NONE};
          state_d = ST_IDLE;
        end
      end
      ST_NAME: if (step) begin
        if (is_alpha(cur_c) || is_digit(cur_c) || (cur_c == CH_UNDER) ||
            (cur_c == CH_COLON)) begin
          if (run_len_q >= RLW'(NAME_BUF - 1)) begin
            r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_NAME_LONG};
            halt_now = 1'b1;
          end else begin
            // Name goes to the buffer and, while there is room, to the next free slot
            nb_we  = 1'b1;
            sym_we = (count_q < IW'(MAX_SYMBOLS));
            if (run_len_q == RLW'(1)) f1_d = cur_c;
            if (run_len_q == RLW'(2)) f2_d = cur_c;
            last_d    = cur_c;
            run_len_d = RLW'(run_len_q + RLW'(1));
          end
        end else if ((run_len_q == RLW'(3)) && (mnem != 4'd0)) begin
          r1_v = 1'b1; r1 = '{kind: TK_MNEMONIC, value: 32'(mnem), err: ERR_NONE};
          do_idle = 1'b1;
        end else if (last_q != CH_COLON) begin
          r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_NO_COLON};
          halt_now = 1'b1;
        end else begin
          // Label: search the table before anything else is taken
          term_d  = cur_c;
          idx_d   = '0;
          base_d  = '0;
          found_d = 1'b0;
          state_d = (count_q == IW'(0)) ? ST_DONE : ST_LEN_RD;
        end
      end
      ST_HALT: ;
      ST_LEN_RD: state_d = ST_LEN_CHK;
      ST_LEN_CHK: begin
        if (len_rd_q == name_len) begin
          if (name_len == JW'(0)) begin
            found_d = 1'b1; state_d = ST_DONE;
          end else begin
            j_d = '0; state_d = ST_CH_RD;
          end
        end else begin
          idx_d  = idx_inc;
          base_d = AW'(base_q + AW'(NAME_BUF));
          state_d = (idx_inc == count_q) ? ST_DONE : ST_LEN_RD;
        end
      end
      ST_CH_RD: state_d = ST_CH_CHK;
      ST_CH_CHK: begin
        if (sym_rd_q != nb_rd_q) begin
          idx_d  = idx_inc;
          base_d = AW'(base_q + AW'(NAME_BUF));
          state_d = (idx_inc == count_q) ? ST_DONE : ST_LEN_RD;
        end else if (j_inc == name_len) begin
          found_d = 1'b1; state_d = ST_DONE;
        end else begin
          j_d = j_inc; state_d = ST_CH_RD;
        end
      end
      ST_DONE: if (step) begin
        if (found_q) begin
          r1_v = 1'b1; r1 = '{kind: TK_LABEL, value: 32'(idx_q), err: ERR_NONE};
          do_idle = 1'b1;
        end else if (count_q >= IW'(MAX_SYMBOLS)) begin
          r1_v = 1'b1; r1 = '{kind: TK_ERROR, value: 32'd0, err: ERR_TAB_FULL};
          halt_now = 1'b1;
        end else begin
          len_we  = 1'b1;
          r1_v = 1'b1; r1 = '{kind: TK_LABEL, value: 32'(count_q), err: ERR_NONE};
          count_d = IW'(count_q + IW'(1));
          wbase_d = AW'(wbase_q + AW'(NAME_BUF));
          do_idle = 1'b1;
        end
      end
      default: state_d = ST_HALT;
    endcase

    if (halt_now) state_d = ST_HALT;

    // Character handled afresh once a run has closed
    if (do_idle) begin
      state_d = idl.nxt;
      if (idl.start_reg) run_len_d = '0;
      if (idl.start_num) begin
        run_len_d = '0; dacc_d = '0; hacc_d = '0;
        lf_zero_d = 1'b0; lf_hex_d = 1'b0; lf_dstop_d = 1'b0; lf_hstop_d = 1'b0;
      end
      if (idl.start_name) begin
        run_len_d = RLW'(1);
        f0_d      = cur_c;
        last_d    = cur_c;
        nb_we     = 1'b1;
        nb_waddr  = '0;
        sym_we    = (count_d < IW'(MAX_SYMBOLS));
        sym_waddr = wbase_d;
      end
    end
  end

  // Order the results of this step
  always_comb begin
    any_res    = r1_v || (do_idle && idl.emit);
    n_res2     = r1_v && do_idle && idl.emit;
    second_res = '{kind: idl.kind, value: 32'd0, err: idl.err};
    first_res  = r1_v ? r1 : second_res;
  end

  // Memories: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (nb_we) nb_mem[nb_waddr] <= wr_char;
    if (sym_we) sym_mem[sym_waddr] <= wr_char;
    if (len_we) len_mem[len_waddr] <= len_wdata;
    nb_rd_q  <= nb_mem[nb_raddr];
    sym_rd_q <= sym_mem[sym_raddr];
    len_rd_q <= len_mem[len_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      run_len_q  <= '0;
      dacc_q     <= '0;
      hacc_q     <= '0;
      lf_zero_q  <= 1'b0;
      lf_hex_q   <= 1'b0;
      lf_dstop_q <= 1'b0;
      lf_hstop_q <= 1'b0;
      count_q    <= '0;
      wbase_q    <= '0;
    end else begin
      state_q    <= state_d;
      run_len_q  <= run_len_d;
      dacc_q     <= dacc_d;
      hacc_q     <= hacc_d;
      lf_zero_q  <= lf_zero_d;
      lf_hex_q   <= lf_hex_d;
      lf_dstop_q <= lf_dstop_d;
      lf_hstop_q <= lf_hstop_d;
      count_q    <= count_d;
      wbase_q    <= wbase_d;
    end
  end

  // Search and name payload
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    j_q     <= j_d;
    base_q  <= base_d;
    found_q <= found_d;
    term_q  <= term_d;
    f0_q    <= f0_d;
    f1_q    <= f1_d;
    f2_q    <= f2_d;
    last_q  <= last_d;
  end

  // Output register with a second stage for the two-token case
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (step && any_res) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= n_res2;
    end else if (pend_valid_q && (!out_valid_q || m_axis_tready)) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= 1'b0;
    end else if (m_axis_tready) begin
      out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && any_res) begin
      out_q      <= first_res;
      out_last_q <= !n_res2;
      pend_q     <= second_res;
    end else if (pend_valid_q && (!out_valid_q || m_axis_tready)) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.err, out_q.value};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: sim/atl_token_checker.sv
// Token checker for the assembly text lexer: watches both stream channels,
// predicts the tokens of each accepted character and compares them in order.
// Depends on atl_pkg for token kinds, error codes and character constants.
`timescale 1ns / 1ps

module atl_token_checker
  import atl_pkg::*;
#(
  parameter int MAX_SYMBOLS    = 512,
  parameter int NAME_BUF       = 128,
  parameter int NUMBER_BUF     = 64,
  parameter int REGISTER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] token_value, [34:32] error_code
  input  logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  input  logic        m_axis_tlast,   // last_of_run
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef enum int {SC_IDLE, SC_REG, SC_NUM, SC_TILDE, SC_CMT, SC_NAME, SC_HALT} scan_e;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [2:0]  err;
    logic        last;
  } token_t;

  localparam string MNEMONICS [12] = '{"lvr", "add", "sub", "mul", "div", "lfp",
                                       "lpi", "lpo", "slv", "vts", "vfs", "com"};

  token_t      token_q [$];
  scan_e       mode = SC_IDLE;
  logic [7:0]  run_chr [NAME_BUF];
  int          run_len = 0;
  logic [31:0] dec_acc = '0;
  logic [31:0] hex_acc = '0;
  logic        lit_zero = 1'b0, lit_hex = 1'b0, dec_stop = 1'b0, hex_stop = 1'b0;
  logic [7:0]  sym_chr [MAX_SYMBOLS][NAME_BUF];
  int          sym_len [MAX_SYMBOLS];
  int          sym_count = 0;
  int          step_tokens;
  int          fails = 0;
  int          checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = token_q.size();
  assign checked_o    = checked;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Hex digit value, -1 when not a hex digit
  function automatic int hex_digit(logic [7:0] c);
    if (digit_c(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic push_token(logic [3:0] kind, logic [31:0] value, logic [2:0] err);
    token_t t;
    t.kind = kind; t.value = value; t.err = err; t.last = 1'b0;
    token_q.push_back(t);
    step_tokens++;
  endtask

  task automatic halt_on(logic [2:0] err);
    push_token(TK_ERROR, '0, err);
    mode = SC_HALT;
  endtask

  // A character seen with no run open
  task automatic lex_fresh(logic [7:0] c);
    case (c)
      CH_NUL:   push_token(TK_END, '0, ERR_NONE);
      CH_SPACE, CH_TAB, CH_LF: ;
      CH_PCT: begin
        mode = SC_REG; run_len = 0;
      end
      CH_DOLLAR: begin
        mode = SC_NUM; run_len = 0; dec_acc = '0; hex_acc = '0;
        lit_zero = 0; lit_hex = 0; dec_stop = 0; hex_stop = 0;
      end
      CH_COMMA: push_token(TK_COMMA, '0, ERR_NONE);
      CH_LBRK:  push_token(TK_LBRACK, '0, ERR_NONE);
      CH_RBRK:  push_token(TK_RBRACK, '0, ERR_NONE);
      CH_LPAR:  push_token(TK_LPAREN, '0, ERR_NONE);
      CH_RPAR:  push_token(TK_RPAREN, '0, ERR_NONE);
      CH_PLUS:  push_token(TK_PLUS, '0, ERR_NONE);
      CH_MINUS: push_token(TK_MINUS, '0, ERR_NONE);
      CH_STAR:  push_token(TK_STAR, '0, ERR_NONE);
      CH_SLASH: push_token(TK_SLASH, '0, ERR_NONE);
      CH_TILDE: mode = SC_TILDE;
      default: begin
        if (alpha_c(c) || c == CH_UNDER) begin
          mode = SC_NAME; run_chr[0] = c; run_len = 1;
        end else begin
          halt_on(ERR_BAD_CHAR);
        end
      end
    endcase
  endtask

  // Register number of the held name, -1 if it is not one
  function automatic int reg_number();
    int v;
    if (run_len < 2 || run_len > 3 || run_chr[0] != CH_R || !digit_c(run_chr[1])) return -1;
    v = run_chr[1] - "0";
    if (run_len == 3) begin
      if (v == 0 || !digit_c(run_chr[2])) return -1;
      v = v * 10 + (run_chr[2] - "0");
    end
    return (v < REGISTER_COUNT) ? v : -1;
  endfunction

  // Mnemonic lookup, then label lookup and insertion
  task automatic close_name();
    int  n;
    bit  same;
    if (run_len == 3) begin
      for (int i = 0; i < 12; i++) begin
        if (run_chr[0] == MNEMONICS[i][0] && run_chr[1] == MNEMONICS[i][1] &&
            run_chr[2] == MNEMONICS[i][2]) begin
          push_token(TK_MNEMONIC, i + 1, ERR_NONE);
          return;
        end
      end
    end
    if (run_len == 0 || run_chr[run_len-1] != CH_COLON) begin
      halt_on(ERR_NO_COLON);
      return;
    end
    n = run_len - 1;
    for (int i = 0; i < sym_count; i++) begin
      if (sym_len[i] == n) begin
        same = 1;
        for (int j = 0; j < n; j++) if (sym_chr[i][j] != run_chr[j]) same = 0;
        if (same) begin
          push_token(TK_LABEL, i, ERR_NONE);
          return;
        end
      end
    end
    if (sym_count >= MAX_SYMBOLS) begin
      halt_on(ERR_TAB_FULL);
      return;
    end
    for (int j = 0; j < n; j++) sym_chr[sym_count][j] = run_chr[j];
    sym_len[sym_count] = n;
    push_token(TK_LABEL, sym_count, ERR_NONE);
    sym_count++;
  endtask

  task automatic lex_char(logic [7:0] c);
    int r, hv;
    step_tokens = 0;
    case (mode)
      SC_HALT: ;
      SC_REG: begin
        if (alpha_c(c) || digit_c(c)) begin
          if (run_len < NAME_BUF) begin
            run_chr[run_len] = c; run_len++;
          end
        end else begin
          r = reg_number();
          if (r < 0) halt_on(ERR_BAD_REG);
          else begin
            push_token(TK_REG, r, ERR_NONE);
            mode = SC_IDLE;
            lex_fresh(c);
          end
        end
      end
      SC_NUM: begin
        hv = hex_digit(c);
        if (hv >= 0 || c == CH_X) begin
          if (run_len >= NUMBER_BUF - 1) halt_on(ERR_NUM_LONG);
          else begin
            if (run_len == 0 && c == CH_ZERO) lit_zero = 1;
            if (run_len == 1 && lit_zero && c == CH_X) lit_hex = 1;
            if (run_len >= 2 && lit_hex && !hex_stop) begin
              if (hv >= 0) hex_acc = hex_acc * 16 + hv;
              else hex_stop = 1;
            end
            if (!dec_stop) begin
              if (digit_c(c)) dec_acc = dec_acc * 10 + (c - "0");
              else dec_stop = 1;
            end
            run_len++;
          end
        end else begin
          push_token(TK_LIT, lit_hex ? hex_acc : dec_acc, ERR_NONE);
          mode = SC_IDLE;
          lex_fresh(c);
        end
      end
      SC_TILDE: begin
        if (c == CH_TILDE) mode = SC_CMT;
        else halt_on(ERR_BAD_CMT);
      end
      SC_CMT: begin
        if (c == CH_LF) mode = SC_IDLE;
        else if (c == CH_NUL) begin
          push_token(TK_END, '0, ERR_NONE);
          mode = SC_IDLE;
        end
      end
      SC_NAME: begin
        if (alpha_c(c) || digit_c(c) || c == CH_UNDER || c == CH_COLON) begin
          if (run_len >= NAME_BUF - 1) halt_on(ERR_NAME_LONG);
          else begin
            run_chr[run_len] = c; run_len++;
          end
        end else begin
          mode = SC_IDLE;
          close_name();
          if (mode != SC_HALT) lex_fresh(c);
        end
      end
      default: begin
        mode = SC_IDLE;
        lex_fresh(c);
      end
    endcase
    if (step_tokens > 0) token_q[token_q.size()-1].last = 1'b1;
  endtask

  task automatic report(string msg);
    $display("%0t: token mismatch: %s", $realtime, msg);
    fails++;
  endtask

  // Outputs are registered, so a token never leaves in its character's cycle
  always @(posedge clk_i) begin
    token_t t;
    if (s_axis_tvalid && s_axis_tready) lex_char(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) begin
      checked++;
      if (token_q.size() == 0) begin
        report($sformatf("unexpected token kind %0d value %0h", m_axis_tuser,
                         m_axis_tdata[31:0]));
      end else begin
        t = token_q.pop_front();
        if (m_axis_tuser !== t.kind || m_axis_tdata[31:0] !== t.value ||
            m_axis_tdata[34:32] !== t.err || m_axis_tlast !== t.last) begin
          report($sformatf("got kind %0d value %0h err %0d last %0b, want %0d %0h %0d %0b",
                           m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[34:32],
                           m_axis_tlast, t.kind, t.value, t.err, t.last));
        end
      end
    end
  end

endmodule

// File: sim/assembly_text_lexer_tb.sv
// Testbench top for the assembly text lexer: drives source text, stalls the
// token side, and gives the verdict. Depends on atl_pkg, the lexer and atl_token_checker.
`timescale 1ns / 1ps

module assembly_text_lexer_tb;
  import atl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] token_value, [34:32] error_code
  logic [3:0]  m_axis_tuser;         // [3:0] token_kind
  logic        m_axis_tlast;

  int fail_count, pending, checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;

  localparam string SEPARATORS = " \t\n,[]()+-*/";
  localparam string HEXCHARS   = "0123456789abcdefABCDEF";
  localparam string NAMECHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string ERR_NAMES [8] = '{"none", "bad char", "bad register", "bad comment",
                                      "long name", "missing colon", "full table",
                                      "long literal"};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  assembly_text_lexer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  atl_token_checker u_checker (
    .clk_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Token side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // One character transfer, with random gaps ahead of it
  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic byte pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic send_separator();
    if ($urandom_range(9) == 0) send_char(CH_NUL);
    else send_char(pick(SEPARATORS));
  endtask

  // One well-formed token, comment or separator with random content
  task automatic send_random_token();
    int    r, n;
    string s;
    r = $urandom_range(99);
    if (r < 14) begin
      send_text($sformatf("%%r%0d", $urandom_range(15)));
      send_separator();
    end else if (r < 32) begin
      if ($urandom_range(1)) begin
        s = "$0x";
        n = $urandom_range(12);
        for (int i = 0; i < n; i++) s = {s, " "};
        for (int i = 3; i < s.len(); i++)
          s[i] = ($urandom_range(15) == 0) ? CH_X : pick(HEXCHARS);
      end else begin
        s = "$";
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) s = {s, " "};
        for (int i = 1; i < s.len(); i++)
          s[i] = ($urandom_range(7) == 0) ? pick(HEXCHARS) : 8'("0" + $urandom_range(9));
      end
      send_text(s);
      send_separator();
    end else if (r < 48) begin
      case ($urandom_range(11))
        0: s = "lvr";  1: s = "add";  2: s = "sub";  3: s = "mul";
        4: s = "div";  5: s = "lfp";  6: s = "lpi";  7: s = "lpo";
        8: s = "slv";  9: s = "vts";  10: s = "vfs"; default: s = "com";
      endcase
      send_text(s);
      send_separator();
    end else if (r < 68) begin
      // mostly a small set of repeated labels, sometimes a fresh one
      if ($urandom_range(3) == 0) begin
        s = "y";
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) s = {s, " "};
        for (int i = 1; i < s.len(); i++)
          s[i] = ($urandom_range(11) == 0) ? CH_COLON : pick(NAMECHARS);
      end else begin
        s = $sformatf("z%0d", $urandom_range(15));
      end
      send_text({s, ":"});
      send_separator();
    end else if (r < 74) begin
      // comment body carries every byte but line feed and end of text
      send_text("~~");
      n = $urandom_range(10);
      for (int i = 0; i < n; i++) begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
        if (s[0] == CH_LF) s[0] = 8'hFF;
        send_char(s[0]);
      end
      send_char($urandom_range(3) == 0 ? CH_NUL : CH_LF);
    end else begin
      send_separator();
    end
  endtask

  // Ends the text with the given error, then sends more text that must give no further token
  task automatic send_error(int kind);
    string s;
    case (kind)
      ERR_BAD_CHAR: begin
        case ($urandom_range(2))
          0: send_char(8'($urandom_range(128, 255)));
          1: send_char(CH_COLON);
          default: send_char(8'("0" + $urandom_range(9)));
        endcase
      end
      ERR_BAD_REG: begin
        case ($urandom_range(3))
          0: send_text("%r16 ");
          1: send_text("%r01,");
          2: send_text("% ");
          default: send_text("%x3abc ");
        endcase
      end
      ERR_BAD_CMT: send_text("~a");
      ERR_NAME_LONG: begin
        send_char("a");
        for (int i = 0; i < 127; i++) send_char(pick(NAMECHARS));
      end
      ERR_NO_COLON: send_text("foo ");
      ERR_TAB_FULL: begin
        // short distinct labels keep the fill near the usual character count
        for (int i = 0; i < 513; i++) begin
          s = "aa: ";
          s[0] = 8'("a" + i / 26);
          s[1] = 8'("a" + i % 26);
          send_text(s);
        end
      end
      default: begin
        send_char(CH_DOLLAR);
        for (int i = 0; i < 64; i++) send_char(8'("0" + $urandom_range(9)));
      end
    endcase
    send_text(",%r1 $5 add\n");
  endtask

  initial begin
    int err_kind;
    int budget;
    int timer;
    err_kind = $urandom_range(ERR_BAD_CHAR, ERR_NUM_LONG);
    budget   = (err_kind == ERR_TAB_FULL) ? 40 : 400;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed text: register and literal extremes, every punctuation, labels
    // found again, a comment holding high bytes, two tokens from one character
    send_text("%r0,%r15[$0x]$4294967296)$0xFFFFFFFFF~~");
    send_char(8'h80); send_char(8'hFF);
    send_text("\n_a:+a_1:*(_a:-/\t$07x9");
    send_char(CH_NUL);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      while (chars_sent < 40 + budget * (ph + 1)) send_random_token();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_error(err_kind);

    timer = 0;
    while (pending != 0 && timer < 200000) begin
      @(negedge clk_i);
      timer++;
    end
    repeat (20) @(negedge clk_i);

    $display("Lexed %0d characters into %0d checked tokens, ending on a %s error.",
             chars_sent, checked, ERR_NAMES[err_kind]);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d tokens never seen", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Run timed out");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/atl_pkg.sv
rtl/assembly_text_lexer.sv
sim/atl_token_checker.sv
sim/assembly_text_lexer_tb.sv
